FILE: design/odwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odwm_pkg
// Shared types, widths, constants and the cosine table for the omni-drive
// wheel mixer.
// ----------------------------------------------------------------------------
package odwm_pkg;

  localparam int COS_FRAC_BITS = 15;
  localparam int SPEED_MAX     = 255;

  localparam int HEADING_W  = 9;
  localparam int SPEED_W    = 8;
  localparam int TRIM_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int COS_W      = COS_FRAC_BITS + 1;
  localparam int ANGLE_W    = 10;
  localparam int IDX_W      = 7;
  localparam int NUM_WHEELS = 4;
  localparam int CFG_IDX_W  = 2;

  // restoring divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = (SPEED_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

  // wheel slots, also the trim register order
  localparam int WHEEL_NE = 0;
  localparam int WHEEL_NW = 1;
  localparam int WHEEL_SE = 2;
  localparam int WHEEL_SW = 3;

  typedef logic [ANGLE_W-1:0] offset_tab_t [NUM_WHEELS];
  localparam offset_tab_t WHEEL_OFFSET = '{10'd45, 10'd315, 10'd135, 10'd225};
  // wheels whose rescaled value is negated (SE and SW)
  localparam logic [NUM_WHEELS-1:0] WHEEL_NEGATE = 4'b1100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NE_TRIM = 2'd0,
    REG_NW_TRIM = 2'd1,
    REG_SE_TRIM = 2'd2,
    REG_SW_TRIM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [HEADING_W-1:0] heading;
    logic [SPEED_W-1:0]   drive_speed;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] ne_duty;
    logic              ne_reverse;
    logic [DUTY_W-1:0] nw_duty;
    logic              nw_reverse;
    logic [DUTY_W-1:0] se_duty;
    logic              se_reverse;
    logic [DUTY_W-1:0] sw_duty;
    logic              sw_reverse;
    logic              no_drive;
  } out_t;

  // cos(d) for d = 0..90 degrees, unsigned Q(COS_FRAC_BITS)
  typedef logic [COS_W-1:0] cos_tab_t [0:90];

  function automatic cos_tab_t build_cos_table();
    cos_tab_t          tab;
    longint unsigned   pi_q30;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint unsigned   rnd;
    pi_q30 = 64'd3373259426;
    for (int d = 0; d <= 90; d++) begin
      if (d == 0) begin
        tab[d] = COS_W'(64'd1 << COS_FRAC_BITS);
      end else if (d == 90) begin
        tab[d] = '0;
      end else begin
        x    = (64'(d) * pi_q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        sum  = 64'sd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 12; k++) begin
          term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
          if ((k % 2) == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        rnd    = (longint'(sum) + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
        tab[d] = COS_W'(rnd);
      end
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TABLE = build_cos_table();

endpackage
`default_nettype wire

FILE: design/odwm_div_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// odwm_div_lane
// Pipelined restoring divider, one lane. Quotient must fit in SPEED_W bits,
// i.e. the top half of the dividend is below the divisor.
// ----------------------------------------------------------------------------
module odwm_div_lane (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [2*odwm_pkg::SPEED_W-1:0] dividend,
  input  wire logic [odwm_pkg::SPEED_W-1:0]   divisor,
  output logic      [odwm_pkg::SPEED_W-1:0]   quotient
);

  localparam int W = odwm_pkg::SPEED_W;
  localparam int S = odwm_pkg::DIV_STAGES;
  localparam int B = odwm_pkg::DIV_BITS_PER_STAGE;

  logic [W-1:0] rem_r   [S];
  logic [W-1:0] low_r   [S];
  logic [W-1:0] quo_r   [S];
  logic [W-1:0] dsr_r   [S];
  logic [W-1:0] rem_nxt [S];
  logic [W-1:0] low_nxt [S];
  logic [W-1:0] quo_nxt [S];
  logic [W-1:0] rem_in  [S];
  logic [W-1:0] low_in  [S];
  logic [W-1:0] quo_in  [S];
  logic [W-1:0] dsr_in  [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = dividend[2*W-1:W];
      assign low_in[s] = dividend[W-1:0];
      assign quo_in[s] = '0;
      assign dsr_in[s] = divisor;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign low_in[s] = low_r[s-1];
      assign quo_in[s] = quo_r[s-1];
      assign dsr_in[s] = dsr_r[s-1];
    end

    always_comb begin
      logic [W:0]   trial;
      logic [W-1:0] rem;
      logic [W-1:0] low;
      logic [W-1:0] quo;
      rem = rem_in[s];
      low = low_in[s];
      quo = quo_in[s];
      for (int b = 0; b < B; b++) begin
        if ((s * B + b) < W) begin
          trial = {rem, low[W-1]};
          low   = {low[W-2:0], 1'b0};
          if (trial >= {1'b0, dsr_in[s]}) begin
            rem = W'(trial - {1'b0, dsr_in[s]});
            quo = {quo[W-2:0], 1'b1};
          end else begin
            rem = trial[W-1:0];
            quo = {quo[W-2:0], 1'b0};
          end
        end
      end
      rem_nxt[s] = rem;
      low_nxt[s] = low;
      quo_nxt[s] = quo;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
        dsr_r[s] <= dsr_in[s];
      end
    end
  end

  assign quotient = quo_r[S-1];

endmodule
`default_nettype wire

FILE: design/omni_drive_wheel_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// omni_drive_wheel_mixer
// X-configured four-wheel omni mixer: heading and speed in, per-wheel duty
// and direction out, with per-wheel trim.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per clock while the output is not stalled,
// with every stage registered. The stages are angle
// fold, cosine table read, speed*cos multiply, largest-magnitude search with
// the rescale product, a 2-bit-per-stage restoring divider, then trim and the
// output register. The whole pipe advances together; in_ready drops only while
// a result sits in the output register and out_ready is low. Trim registers
// are written through the cfg port (always ready) and must only change while
// no transaction is in flight.
module omni_drive_wheel_mixer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire odwm_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output odwm_pkg::out_t                         out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [odwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [odwm_pkg::TRIM_W-1:0]       cfg_data
);

  localparam int NW_ = odwm_pkg::NUM_WHEELS;
  localparam int SW_ = odwm_pkg::SPEED_W;
  localparam int DS  = odwm_pkg::DIV_STAGES;
  localparam int PRE = 4;                 // stages ahead of the divider
  localparam int DEPTH = PRE + DS;

  typedef struct packed {
    logic [NW_-1:0] neg;
    logic [NW_-1:0] nz;
    logic           none;
  } side_t;

  logic en;
  logic [DEPTH-1:0] vld_r;
  logic             out_valid_r;
  odwm_pkg::out_t   out_r;
  odwm_pkg::out_t   out_nxt;

  logic [odwm_pkg::TRIM_W-1:0] trim_r [NW_];

  // stage 1: fold
  logic [odwm_pkg::IDX_W-1:0] s1_idx_r   [NW_];
  logic [odwm_pkg::IDX_W-1:0] s1_idx_nxt [NW_];
  logic [NW_-1:0]             s1_neg_r;
  logic [NW_-1:0]             s1_neg_nxt;
  logic [SW_-1:0]             s1_speed_r;
  logic [SW_-1:0]             s1_speed_nxt;
  // stage 2: cosine
  logic [odwm_pkg::COS_W-1:0] s2_cos_r [NW_];
  logic [NW_-1:0]             s2_neg_r;
  logic [SW_-1:0]             s2_speed_r;
  // stage 3: raw magnitude
  logic [SW_-1:0]             s3_mag_r   [NW_];
  logic [SW_-1:0]             s3_mag_nxt [NW_];
  logic [NW_-1:0]             s3_neg_r;
  logic [SW_-1:0]             s3_speed_r;
  // stage 4: largest and rescale product
  logic [2*SW_-1:0]           s4_prod_r [NW_];
  logic [SW_-1:0]             s4_largest_r;
  logic [SW_-1:0]             s4_largest_nxt;
  side_t                      s4_side_r;
  side_t                      s4_side_nxt;
  // divider side band
  side_t                      side_r [DS];
  logic [SW_-1:0]             quo    [NW_];

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // trim registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NW_; w++) trim_r[w] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        odwm_pkg::REG_NE_TRIM: trim_r[odwm_pkg::WHEEL_NE] <= cfg_data;
        odwm_pkg::REG_NW_TRIM: trim_r[odwm_pkg::WHEEL_NW] <= cfg_data;
        odwm_pkg::REG_SE_TRIM: trim_r[odwm_pkg::WHEEL_SE] <= cfg_data;
        odwm_pkg::REG_SW_TRIM: trim_r[odwm_pkg::WHEEL_SW] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  // stage 1: heading + offset mod 360, folded into 0..90 with a sign
  always_comb begin
    logic [odwm_pkg::ANGLE_W-1:0] a;
    if (32'(in_data.drive_speed) > odwm_pkg::SPEED_MAX) begin
      s1_speed_nxt = SW_'(odwm_pkg::SPEED_MAX);
    end else begin
      s1_speed_nxt = in_data.drive_speed;
    end
    for (int w = 0; w < NW_; w++) begin
      a = odwm_pkg::ANGLE_W'(in_data.heading) + odwm_pkg::WHEEL_OFFSET[w];
      if (a >= 10'd720) a = a - 10'd720;
      else if (a >= 10'd360) a = a - 10'd360;
      if (a <= 10'd90) begin
        s1_idx_nxt[w] = odwm_pkg::IDX_W'(a);
        s1_neg_nxt[w] = 1'b0;
      end else if (a <= 10'd180) begin
        s1_idx_nxt[w] = odwm_pkg::IDX_W'(10'd180 - a);
        s1_neg_nxt[w] = 1'b1;
      end else if (a <= 10'd270) begin
        s1_idx_nxt[w] = odwm_pkg::IDX_W'(a - 10'd180);
        s1_neg_nxt[w] = 1'b1;
      end else begin
        s1_idx_nxt[w] = odwm_pkg::IDX_W'(10'd360 - a);
        s1_neg_nxt[w] = 1'b0;
      end
    end
  end

  // stage 3 multiply, truncated
  always_comb begin
    logic [SW_+odwm_pkg::COS_W-1:0] p;
    for (int w = 0; w < NW_; w++) begin
      p = (SW_+odwm_pkg::COS_W)'(s2_speed_r) * (SW_+odwm_pkg::COS_W)'(s2_cos_r[w]);
      s3_mag_nxt[w] = p[odwm_pkg::COS_FRAC_BITS +: SW_];
    end
  end

  // stage 4: largest magnitude
  always_comb begin
    s4_largest_nxt = s3_mag_r[0];
    for (int w = 1; w < NW_; w++) begin
      if (s3_mag_r[w] > s4_largest_nxt) s4_largest_nxt = s3_mag_r[w];
    end
    s4_side_nxt.neg  = s3_neg_r;
    for (int w = 0; w < NW_; w++) s4_side_nxt.nz[w] = (s3_mag_r[w] != '0);
    s4_side_nxt.none = (s4_side_nxt.nz == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < NW_; w++) begin
        s1_idx_r[w]  <= s1_idx_nxt[w];
        s2_cos_r[w]  <= odwm_pkg::COS_TABLE[s1_idx_r[w]];
        s3_mag_r[w]  <= s3_mag_nxt[w];
        s4_prod_r[w] <= (2*SW_)'(s3_mag_r[w]) * (2*SW_)'(s3_speed_r);
      end
      s1_neg_r     <= s1_neg_nxt;
      s1_speed_r   <= s1_speed_nxt;
      s2_neg_r     <= s1_neg_r;
      s2_speed_r   <= s1_speed_r;
      s3_neg_r     <= s2_neg_r;
      s3_speed_r   <= s2_speed_r;
      s4_largest_r <= s4_largest_nxt;
      s4_side_r    <= s4_side_nxt;
      side_r[0]    <= s4_side_r;
      for (int s = 1; s < DS; s++) side_r[s] <= side_r[s-1];
      out_r        <= out_nxt;
    end
  end

  for (genvar w = 0; w < NW_; w++) begin : g_lane
    odwm_div_lane u_div (
      .clk      (clk),
      .en       (en),
      .dividend (s4_prod_r[w]),
      .divisor  (s4_largest_r),
      .quotient (quo[w])
    );
  end

  // trim, floor at zero; a nonzero raw magnitude always rescales to nonzero
  always_comb begin
    logic [odwm_pkg::DUTY_W-1:0] duty [NW_];
    logic [NW_-1:0]              rev;
    for (int w = 0; w < NW_; w++) begin
      if (!side_r[DS-1].none && quo[w] > trim_r[w]) begin
        duty[w] = odwm_pkg::DUTY_W'(quo[w] - trim_r[w]);
      end else begin
        duty[w] = '0;
      end
      rev[w] = side_r[DS-1].nz[w] & (side_r[DS-1].neg[w] ^ odwm_pkg::WHEEL_NEGATE[w]);
    end
    out_nxt.ne_duty    = duty[odwm_pkg::WHEEL_NE];
    out_nxt.ne_reverse = rev[odwm_pkg::WHEEL_NE];
    out_nxt.nw_duty    = duty[odwm_pkg::WHEEL_NW];
    out_nxt.nw_reverse = rev[odwm_pkg::WHEEL_NW];
    out_nxt.se_duty    = duty[odwm_pkg::WHEEL_SE];
    out_nxt.se_reverse = rev[odwm_pkg::WHEEL_SE];
    out_nxt.sw_duty    = duty[odwm_pkg::WHEEL_SW];
    out_nxt.sw_reverse = rev[odwm_pkg::WHEEL_SW];
    out_nxt.no_drive   = side_r[DS-1].none;
  end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the omni-drive wheel mixer. Heading/speed commands
// are fed through a bursty valid/ready driver; each accepted command is run
// through an in-bench X-drive kinematics predictor (own Taylor cosine, speed
// normalisation, trim) and every result is compared field by field. Trim
// settings change between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import odwm_pkg::*;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int HOLD_AT  = 150;
  localparam int HOLD_LEN = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TRIM_W-1:0] cfg_data = '0;

  in_t  cmd_q [$];
  out_t wheel_q [$];
  logic [TRIM_W-1:0] trim_shadow [4] = '{default: '0};
  int   mismatch_cnt = 0;
  int   taken_cnt = 0;
  logic in_done = 1'b0;

  always #1 clk = ~clk;

  omni_drive_wheel_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // cos(d) for d in 0..90, unsigned Q(COS_FRAC_BITS), 12-term Q30 series
  function automatic longint unsigned cos_quadrant(int unsigned d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    if (d == 0) return 64'd1 << COS_FRAC_BITS;
    if (d >= 90) return 64'd0;
    x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    acc  = 64'sd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return (64'(acc) + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
  endfunction

  // trunc(speed * cos(angle)), signed
  function automatic longint wheel_raw(int unsigned angle, longint unsigned spd);
    int unsigned     f;
    longint unsigned c;
    longint unsigned m;
    bit              neg;
    f = angle % 360;
    if (f <= 90) begin
      c = cos_quadrant(f);
      neg = 1'b0;
    end else if (f <= 180) begin
      c = cos_quadrant(180 - f);
      neg = 1'b1;
    end else if (f <= 270) begin
      c = cos_quadrant(f - 180);
      neg = 1'b1;
    end else begin
      c = cos_quadrant(360 - f);
      neg = 1'b0;
    end
    m = (spd * c) >> COS_FRAC_BITS;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // {duty, reverse} of one wheel after trim
  function automatic logic [DUTY_W:0] wheel_drive(longint v, logic [TRIM_W-1:0] trim);
    longint m;
    longint duty;
    m = (v < 0) ? -v : v;
    duty = (m > longint'(trim)) ? m - longint'(trim) : 0;
    if (duty > 255) duty = 255;
    return {DUTY_W'(duty), v < 0};
  endfunction

  function automatic out_t mix_wheels(in_t cmd);
    longint      spd;
    longint      largest;
    longint      m;
    longint      w [4];
    int unsigned offs [4];
    out_t        r;
    offs = '{45, 315, 135, 225};  // NE, NW, SE, SW
    spd = longint'(cmd.drive_speed);
    if (spd > SPEED_MAX) spd = SPEED_MAX;
    largest = 0;
    for (int i = 0; i < 4; i++) begin
      w[i] = wheel_raw(int'(cmd.heading) + offs[i], longint'(spd));
      m = (w[i] < 0) ? -w[i] : w[i];
      if (m > largest) largest = m;
    end
    r = '0;
    if (largest == 0) begin
      r.no_drive = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      w[i] = w[i] * spd / largest;
      if (i == WHEEL_SE || i == WHEEL_SW) w[i] = -w[i];
    end
    {r.ne_duty, r.ne_reverse} = wheel_drive(w[WHEEL_NE], trim_shadow[REG_NE_TRIM]);
    {r.nw_duty, r.nw_reverse} = wheel_drive(w[WHEEL_NW], trim_shadow[REG_NW_TRIM]);
    {r.se_duty, r.se_reverse} = wheel_drive(w[WHEEL_SE], trim_shadow[REG_SE_TRIM]);
    {r.sw_duty, r.sw_reverse} = wheel_drive(w[WHEEL_SW], trim_shadow[REG_SW_TRIM]);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // driver: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_data  <= cmd_q.pop_front();
        in_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off to back the pipe up
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 48);
      end else begin
        mode_left = mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin : mon
    out_t want;
    in_done <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (wheel_q.size() == 0) begin
          $error("unexpected result transaction");
          mismatch_cnt++;
        end else begin
          want = wheel_q.pop_front();
          check_field("ne_duty",    want.ne_duty,    out_data.ne_duty);
          check_field("ne_reverse", want.ne_reverse, out_data.ne_reverse);
          check_field("nw_duty",    want.nw_duty,    out_data.nw_duty);
          check_field("nw_reverse", want.nw_reverse, out_data.nw_reverse);
          check_field("se_duty",    want.se_duty,    out_data.se_duty);
          check_field("se_reverse", want.se_reverse, out_data.se_reverse);
          check_field("sw_duty",    want.sw_duty,    out_data.sw_duty);
          check_field("sw_reverse", want.sw_reverse, out_data.sw_reverse);
          check_field("no_drive",   want.no_drive,   out_data.no_drive);
        end
      end
      if (in_valid && in_ready) begin
        wheel_q.push_back(mix_wheels(in_data));
        taken_cnt = taken_cnt + 1;
      end
    end
  end

  function automatic void push_cmd(int unsigned hdg, int unsigned spd);
    in_t c;
    c.heading     = HEADING_W'(hdg);
    c.drive_speed = SPEED_W'(spd);
    cmd_q.push_back(c);
  endfunction

  task automatic write_trim(input cfg_reg_t sel, input logic [TRIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trim_shadow[sel] = val;
  endtask

  task automatic set_trims(input logic [TRIM_W-1:0] ne, input logic [TRIM_W-1:0] nw,
                           input logic [TRIM_W-1:0] se, input logic [TRIM_W-1:0] sw);
    write_trim(REG_NE_TRIM, ne);
    write_trim(REG_NW_TRIM, nw);
    write_trim(REG_SE_TRIM, se);
    write_trim(REG_SW_TRIM, sw);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // every result is back before trims may change
  task automatic drain();
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || wheel_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [TRIM_W-1:0] pick_trim();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return TRIM_W'($urandom_range(0, 30));
      default: return TRIM_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stim
    int unsigned hdg;
    int unsigned spd;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    set_trims('0, '0, '0, '0);
    // cardinal and diagonal headings at full speed
    for (int i = 0; i < 8; i++) push_cmd(i * 45, 255);
    push_cmd(359, 255);
    push_cmd(360, 255);      // wraps to 0
    push_cmd(405, 200);      // wraps to 45
    push_cmd(511, 255);      // all heading bits set
    push_cmd(1, 128);
    push_cmd(44, 100);
    push_cmd(0, 0);          // zero speed: no drive
    push_cmd(0, 1);          // every raw wheel truncates to zero
    push_cmd(45, 1);
    push_cmd(511, 0);
    drain();

    // trims at or above every magnitude: duties floored, directions kept
    set_trims('1, '1, '1, '1);
    push_cmd(0, 255);
    push_cmd(30, 255);
    push_cmd(135, 255);
    push_cmd(300, 254);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_trims(pick_trim(), pick_trim(), pick_trim(), pick_trim());
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 3) == 0) hdg = $urandom_range(0, 11) * 45;
        else hdg = $urandom_range(0, 511);
        case ($urandom_range(0, 7))
          0: spd = $urandom_range(0, 3);
          1: spd = 255;
          default: spd = $urandom_range(0, 255);
        endcase
        push_cmd(hdg, spd);
      end
      drain();
    end

    repeat (DIV_STAGES + 8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: omni_drive_wheel_mixer.f
design/odwm_pkg.sv
design/odwm_div_lane.sv
design/omni_drive_wheel_mixer.sv
tb/tb_top.sv
